// File: hdl/multi_axis_p_control_offset_avg_defines.svh
// ---------------------------------------------------------------------------
// assertion macros for the offset averaging controller
// ---------------------------------------------------------------------------
`ifndef MULTI_AXIS_P_CONTROL_OFFSET_AVG_DEFINES_SVH
`define MULTI_AXIS_P_CONTROL_OFFSET_AVG_DEFINES_SVH
`ifndef SYNTHESIS
`define MAPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MAPC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/mapc_pkg.sv
// ---------------------------------------------------------------------------
// mapc_pkg
// types and constants of the multi-axis position controller
// ---------------------------------------------------------------------------
`default_nettype none
package mapc_pkg;
   localparam int AXIS_COUNT = 6;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_GAIN0 = 3'd0, REG_GAIN1 = 3'd1, REG_GAIN2 = 3'd2, REG_GAIN3 = 3'd3,
      REG_GAIN4 = 3'd4, REG_GAIN5 = 3'd5, REG_AXES = 3'd6, REG_MINWAIT = 3'd7
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_ACC, ST_PUB, ST_OUT
   } state_type;

   // divider control and status
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: hdl/mapc_if.sv
// ---------------------------------------------------------------------------
// mapc channel interfaces
// valid/ready channels for items, results and register writes
// ---------------------------------------------------------------------------
`default_nettype none
interface mapc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [2:0]  axis;
   logic signed [31:0] desired_pos;
   logic signed [31:0] measured_pos;
   logic        end_of_period;
   logic [15:0] wait_periods;
   logic [15:0] sample_count;
   modport source (output valid, command, axis, desired_pos, measured_pos,
                   end_of_period, wait_periods, sample_count, input ready);
   modport sink (input valid, command, axis, desired_pos, measured_pos,
                 end_of_period, wait_periods, sample_count, output ready);
endinterface

interface mapc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  out_axis;
   logic signed [31:0] velocity;
   logic signed [31:0] published_offset;
   logic        measurement_done;
   logic        start_accepted;
   logic        last_result;
   modport source (output valid, out_axis, velocity, published_offset,
                   measurement_done, start_accepted, last_result, input ready);
   modport sink (input valid, out_axis, velocity, published_offset,
                 measurement_done, start_accepted, last_result, output ready);
endinterface

interface mapc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/mapc_div.sv
// ---------------------------------------------------------------------------
// mapc_div
// serial signed divide, truncating toward zero, one quotient bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none
module mapc_div
   import mapc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] mag;

   // magnitude of dividend
   assign mag = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
   assign trial = {rem_ff, quo_ff[31]} - {17'd0, dsr_ff};

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (req.start) begin
         rem_in = '0; quo_in = mag; dsr_in = req.divisor; neg_in = req.dividend[31];
         cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;
endmodule
`default_nettype wire

// File: hdl/multi_axis_p_control_offset_avg.sv
// ---------------------------------------------------------------------------
// multi_axis_p_control_offset_avg
// per-axis proportional position controller with offset averaging
// ---------------------------------------------------------------------------
// Usage: items enter on req (sample, start, stop), results leave on rsp.
// Gains, axis count and least wait are to be written on csr only while idle;
// the block itself does not enforce this. A sample item yields one result
// with velocity = gain * (desired - measured), gain in Q8.8 (product shifted
// right by 8), saturated. Outside the sampling phase a sample item goes
// through multiply, update and result load, then the result handshake.
// During the sampling phase the velocity of an axis in use is divided by the
// sample count in a serial divider (32 steps plus start and done) before it
// is added to the accumulator.
// The period that ends a measurement walks the six accumulators, one a
// cycle, to publish them. A start item yields one result; a stop item gives
// one result per axis in use.
// req is ready only when no item is in work and no result waits; the result
// register holds a result until rsp.ready, and a stall holds back the item.
// Reset clears accumulators, published offsets, counters and gains, and
// sets the axis count to 6 and the least wait to 1000.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_axis_p_control_offset_avg_defines.svh"
module multi_axis_p_control_offset_avg
   import mapc_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   mapc_req_if.sink   req,
   mapc_rsp_if.source rsp,
   mapc_csr_if.sink   csr
);
   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   state_type st_ff, st_in;
   logic signed [15:0] gain_ff [AXIS_COUNT];
   logic [2:0]  axes_ff;
   logic [15:0] minwait_ff;
   logic signed [47:0] acc_ff [AXIS_COUNT];
   logic signed [31:0] pub_ff [AXIS_COUNT];
   logic        meas_ff;
   logic [15:0] per_ff, wtgt_ff, stgt_ff, stk_ff;

   // latched item
   logic [1:0]  cmd_ff;
   logic [2:0]  ax_ff;
   logic signed [32:0] err_ff;
   logic        eop_ff;
   logic signed [31:0] vel_ff;
   logic [2:0]  idx_ff;

   // result register
   logic        ov_ff;
   logic [2:0]  oax_ff;
   logic signed [31:0] ovel_ff, opub_ff;
   logic        odone_ff, oacc_ff, olast_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [2:0] used;
   logic       in_acc;
   logic       sampling;
   logic signed [48:0] prod;
   logic signed [40:0] q;
   logic signed [31:0] vel_sat;
   logic signed [48:0] acc_sum;
   logic               ax_ok;

   mapc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign used = (axes_ff == 3'd0) ? 3'd1 :
                 (axes_ff > 3'(AXIS_COUNT)) ? 3'(AXIS_COUNT) : axes_ff;
   assign in_acc = req.valid && req.ready;
   assign sampling = meas_ff && (per_ff >= wtgt_ff);
   assign ax_ok = ax_ff < used;

   assign req.ready = (st_ff == ST_IDLE) && !ov_ff;
   assign csr.ready = 1'b1;

   // product and rounding toward minus infinity (arithmetic shift)
   assign prod = 49'(gain_ff[ax_ok ? ax_ff : 3'd0]) * 49'(err_ff);
   assign q = 41'(prod >>> 8);
   assign vel_sat = (q > 41'sd2147483647) ? 32'sh7FFF_FFFF :
                    (q < -41'sd2147483648) ? 32'sh8000_0000 : 32'(q);
   assign acc_sum = 49'(acc_ff[ax_ok ? ax_ff : 3'd0]) + 49'(signed'(drsp.quotient));

   assign dreq.start = (st_ff == ST_MUL) && ax_ok && sampling;
   assign dreq.dividend = vel_sat;
   assign dreq.divisor = stgt_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (in_acc) begin
            unique case (cmd_type'(req.command))
               CMD_SAMPLE: st_in = ST_MUL;
               CMD_START, CMD_STOP: st_in = ST_OUT;
               default: st_in = ST_IDLE;
            endcase
         end
         ST_MUL: st_in = (ax_ok && sampling) ? ST_DIV : ST_ACC;
         ST_DIV: if (drsp.done) st_in = ST_ACC;
         ST_ACC: st_in = (eop_ff && sampling && (stk_ff + 16'd1 >= stgt_ff))
                         ? ST_PUB : ST_OUT;
         ST_PUB: if (idx_ff == 3'(AXIS_COUNT - 1)) st_in = ST_OUT;
         ST_OUT: if (!ov_ff) begin
            if (cmd_type'(cmd_ff) == CMD_STOP && idx_ff + 3'd1 < used) st_in = ST_OUT;
            else st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            gain_ff[i] <= '0; acc_ff[i] <= '0; pub_ff[i] <= '0;
         end
         axes_ff <= 3'd6; minwait_ff <= 16'd1000;
         meas_ff <= 1'b0; per_ff <= '0; wtgt_ff <= '0; stgt_ff <= 16'd1; stk_ff <= '0;
         ov_ff <= 1'b0; idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (rsp.valid && rsp.ready) ov_ff <= 1'b0;
         // register writes
         if (csr.valid) begin
            unique case (reg_type'(csr.index))
               REG_AXES:    axes_ff <= csr.data[2:0];
               REG_MINWAIT: minwait_ff <= csr.data;
               default:     gain_ff[csr.index] <= csr.data;
            endcase
         end
         unique case (st_ff)
            ST_IDLE: if (in_acc) begin
               cmd_ff <= req.command; ax_ff <= req.axis; eop_ff <= req.end_of_period;
               err_ff <= 33'(req.desired_pos) - 33'(req.measured_pos);
               idx_ff <= '0;
               if (cmd_type'(req.command) == CMD_START && !meas_ff) begin
                  for (int i = 0; i < AXIS_COUNT; i++) acc_ff[i] <= '0;
                  wtgt_ff <= (req.wait_periods > minwait_ff) ? req.wait_periods : minwait_ff;
                  stgt_ff <= (req.sample_count == 16'd0) ? 16'd1 : req.sample_count;
                  per_ff <= '0; stk_ff <= '0; meas_ff <= 1'b1;
                  oacc_ff <= 1'b1;
               end else oacc_ff <= 1'b0;
            end
            ST_MUL: vel_ff <= ax_ok ? vel_sat : 32'sd0;
            ST_ACC: begin
               if (ax_ok && sampling)
                  acc_ff[ax_ff] <= (acc_sum > 49'(ACC_MAX)) ? ACC_MAX :
                                   (acc_sum < 49'(ACC_MIN)) ? ACC_MIN : 48'(acc_sum);
               if (eop_ff && meas_ff) begin
                  if (sampling) begin
                     stk_ff <= stk_ff + 16'd1;
                     if (stk_ff + 16'd1 >= stgt_ff) meas_ff <= 1'b0;
                  end else if (per_ff != 16'hFFFF) per_ff <= per_ff + 16'd1;
               end
            end
            ST_PUB: begin
               pub_ff[idx_ff] <= (acc_ff[idx_ff] > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                 (acc_ff[idx_ff] < -48'sh8000_0000) ? 32'sh8000_0000 :
                                 32'(acc_ff[idx_ff]);
               if (idx_ff == 3'(AXIS_COUNT - 1)) idx_ff <= '0;
               else idx_ff <= idx_ff + 3'd1;
            end
            ST_OUT: if (!ov_ff) begin
               ov_ff <= 1'b1;
               odone_ff <= !meas_ff;
               unique case (cmd_type'(cmd_ff))
                  CMD_SAMPLE: begin
                     oax_ff <= ax_ff; ovel_ff <= vel_ff; olast_ff <= 1'b1;
                     opub_ff <= (ax_ff < 3'(AXIS_COUNT)) ? pub_ff[ax_ff] : 32'sd0;
                  end
                  CMD_STOP: begin
                     oax_ff <= idx_ff; ovel_ff <= '0; opub_ff <= pub_ff[idx_ff];
                     olast_ff <= (idx_ff + 3'd1 >= used);
                     idx_ff <= idx_ff + 3'd1;
                  end
                  default: begin
                     oax_ff <= '0; ovel_ff <= '0; opub_ff <= pub_ff[0]; olast_ff <= 1'b1;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.out_axis = oax_ff;
   assign rsp.velocity = ovel_ff;
   assign rsp.published_offset = opub_ff;
   assign rsp.measurement_done = odone_ff;
   assign rsp.start_accepted = oacc_ff && (cmd_type'(cmd_ff) == CMD_START);
   assign rsp.last_result = olast_ff;

   `MAPC_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, st_ff == ST_IDLE)
   `MAPC_ASSERT_NEXT(a_div_start, clock, reset, dreq.start, drsp.busy)
   `MAPC_ASSERT_IMPL(a_div_only, clock, reset, drsp.busy, st_ff == ST_DIV)
   `MAPC_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
                     rsp.valid && $stable(rsp.velocity))
endmodule
`default_nettype wire

// File: sim/multi_axis_p_control_offset_avg_test.sv
// ---------------------------------------------------------------------------
// multi_axis_p_control_offset_avg_test
// drives sample, start, stop and none items plus register writes into the
// controller, predicts every result in a local model and checks each field
// ---------------------------------------------------------------------------
`default_nettype none
module multi_axis_p_control_offset_avg_test
   import mapc_pkg::*;
;
   localparam int WATCHDOG_CYCLES = 20000;

   typedef struct {
      logic [2:0]  out_axis;
      logic [31:0] velocity;
      logic [31:0] published_offset;
      logic        measurement_done;
      logic        start_accepted;
      logic        last_result;
   } ctrl_result_type;

   typedef struct {
      cmd_type     command;
      logic [2:0]  axis;
      logic [31:0] desired_pos;
      logic [31:0] measured_pos;
      logic        end_of_period;
      logic [15:0] wait_periods;
      logic [15:0] sample_count;
      logic        typed;       // expected velocity given in the row
      logic [31:0] typed_vel;
   } ctrl_item_type;

   logic clock;
   logic reset;

   mapc_req_if req();
   mapc_rsp_if rsp();
   mapc_csr_if csr();

   multi_axis_p_control_offset_avg i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // controller state mirror
   logic signed [15:0] gain_reg [AXIS_COUNT];
   logic [2:0]         axes_reg;
   logic [15:0]        min_wait_reg;
   logic signed [47:0] accum [AXIS_COUNT];
   logic signed [31:0] published [AXIS_COUNT];
   logic               measuring;
   logic [15:0]        periods_elapsed;
   logic [15:0]        wait_target;
   logic [15:0]        sample_target;
   logic [15:0]        samples_taken;

   ctrl_result_type expected_results[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int axes_effective();
      int n;
      n = axes_reg;
      if (n == 0) n = 1;
      if (n > AXIS_COUNT) n = AXIS_COUNT;
      return n;
   endfunction

   function automatic logic [31:0] offset_of(int a);
      return (a < AXIS_COUNT) ? published[a] : 32'sd0;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void push_result(int a, logic [31:0] vel, logic acc, logic last);
      ctrl_result_type r;
      r.out_axis = a[2:0];
      r.velocity = vel;
      r.published_offset = offset_of(a);
      r.measurement_done = !measuring;
      r.start_accepted = acc;
      r.last_result = last;
      expected_results.push_back(r);
   endfunction

   // predicts the results of one item and updates the mirrored state
   function automatic void predict_item(ctrl_item_type it);
      logic signed [63:0] err, prod, q, sum;
      logic signed [31:0] vel;
      logic signed [47:0] share;
      logic sampling;
      int used, a;
      used = axes_effective();
      a = it.axis;
      vel = 0;
      case (it.command)
         CMD_SAMPLE: begin
            sampling = measuring && (periods_elapsed >= wait_target);
            if (a < used) begin
               err = $signed(it.desired_pos) - $signed(it.measured_pos);
               prod = gain_reg[a] * err;
               q = prod >>> 8;
               vel = sat32(q);
               if (sampling) begin
                  share = 48'(64'(vel) / $signed({48'd0, sample_target}));
                  sum = 64'(accum[a]) + 64'(share);
                  if (sum > 64'sh7fffffffffff) accum[a] = 48'sh7fffffffffff;
                  else if (sum < -64'sh800000000000) accum[a] = 48'sh800000000000;
                  else accum[a] = sum[47:0];
               end
            end
            if (it.end_of_period && measuring) begin
               if (sampling) begin
                  samples_taken++;
                  if (samples_taken >= sample_target) begin
                     measuring = 1'b0;
                     for (int i = 0; i < AXIS_COUNT; i++)
                        published[i] = sat32(64'(accum[i]));
                  end
               end else if (periods_elapsed != 16'hffff) begin
                  periods_elapsed++;
               end
            end
            push_result(a, vel, 1'b0, 1'b1);
         end
         CMD_START: begin
            logic acc;
            acc = !measuring;
            if (acc) begin
               for (int i = 0; i < AXIS_COUNT; i++) accum[i] = 0;
               wait_target = (it.wait_periods > min_wait_reg) ? it.wait_periods
                                                              : min_wait_reg;
               sample_target = (it.sample_count == 16'd0) ? 16'd1 : it.sample_count;
               periods_elapsed = 0;
               samples_taken = 0;
               measuring = 1'b1;
            end
            push_result(0, 32'd0, acc, 1'b1);
         end
         CMD_STOP: begin
            for (int i = 0; i < used; i++)
               push_result(i, 32'd0, 1'b0, i + 1 == used);
         end
         default: ;
      endcase
   endfunction

   function automatic void reset_mirror();
      for (int i = 0; i < AXIS_COUNT; i++) begin
         gain_reg[i] = 0;
         accum[i] = 0;
         published[i] = 0;
      end
      axes_reg = 3'd6;
      min_wait_reg = 16'd1000;
      measuring = 1'b0;
      periods_elapsed = 0;
      wait_target = 0;
      sample_target = 16'd1;
      samples_taken = 0;
   endfunction

   // random idle bursts on the sender side
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   task automatic send_item(ctrl_item_type it);
      sender_gap();
      req.valid <= 1'b1;
      req.command <= it.command;
      req.axis <= it.axis;
      req.desired_pos <= it.desired_pos;
      req.measured_pos <= it.measured_pos;
      req.end_of_period <= it.end_of_period;
      req.wait_periods <= it.wait_periods;
      req.sample_count <= it.sample_count;
      do @(posedge clock); while (!req.ready);
      req.valid <= 1'b0;
      predict_item(it);
      if (it.typed && expected_results.size() > 0)
         expected_results[$].velocity = it.typed_vel;
      // the block is busy for this cycle anyway
      @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [15:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         REG_AXES: axes_reg = value[2:0];
         REG_MINWAIT: min_wait_reg = value;
         default: gain_reg[idx] = value;
      endcase
      @(posedge clock);
   endtask

   // waits for all results, then idles before returning
   task automatic drain();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic ctrl_item_type mk(cmd_type c, int a, logic [31:0] d, logic [31:0] m,
                                        int eop, int w, int s);
      ctrl_item_type it;
      it.command = c;
      it.axis = a[2:0];
      it.desired_pos = d;
      it.measured_pos = m;
      it.end_of_period = eop[0];
      it.wait_periods = w[15:0];
      it.sample_count = s[15:0];
      it.typed = 1'b0;
      it.typed_vel = 0;
      return it;
   endfunction

   function automatic ctrl_item_type mk_typed(ctrl_item_type it, logic [31:0] v);
      it.typed = 1'b1;
      it.typed_vel = v;
      return it;
   endfunction

   function automatic ctrl_item_type random_sample();
      ctrl_item_type it;
      it = mk(CMD_SAMPLE, $urandom_range(0, 7), $urandom, $urandom, 0,
              $urandom, $urandom);
      if ($urandom_range(0, 1)) begin
         it.desired_pos = $urandom_range(0, 1) ? $urandom_range(0, 20000000)
                                               : -$urandom_range(0, 20000000);
         it.measured_pos = $urandom_range(0, 20000000) - 10000000;
      end
      return it;
   endfunction

   // one control period over the axes in use
   task automatic run_period(int axes);
      ctrl_item_type it;
      for (int a = 0; a < axes; a++) begin
         it = random_sample();
         it.axis = a[2:0];
         it.end_of_period = (a == axes - 1);
         send_item(it);
      end
   endtask

   // result checker, with random stall bursts on the receiver side
   always @(posedge clock) begin
      ctrl_result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            idle_cycles <= 0;
            if (expected_results.size() == 0) begin
               $error("result with no expectation, axis %0d", rsp.out_axis);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp.out_axis !== e.out_axis) begin
                  $error("out_axis exp %0d got %0d", e.out_axis, rsp.out_axis);
                  error_count++;
               end
               if (rsp.velocity !== e.velocity) begin
                  $error("velocity exp %0d got %0d", $signed(e.velocity), rsp.velocity);
                  error_count++;
               end
               if (rsp.published_offset !== e.published_offset) begin
                  $error("published_offset exp %0d got %0d",
                         $signed(e.published_offset), rsp.published_offset);
                  error_count++;
               end
               if (rsp.measurement_done !== e.measurement_done) begin
                  $error("measurement_done exp %0b got %0b",
                         e.measurement_done, rsp.measurement_done);
                  error_count++;
               end
               if (rsp.start_accepted !== e.start_accepted) begin
                  $error("start_accepted exp %0b got %0b",
                         e.start_accepted, rsp.start_accepted);
                  error_count++;
               end
               if (rsp.last_result !== e.last_result) begin
                  $error("last_result exp %0b got %0b", e.last_result, rsp.last_result);
                  error_count++;
               end
            end
         end else if ((req.valid && req.ready) || (csr.valid && csr.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (calm) begin
            rsp.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp.ready <= (stall_left == 1);
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 16);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      ctrl_item_type directed [$];
      int axes;
      int periods;
      calm = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.command = CMD_SAMPLE;
      req.axis = 0;
      req.desired_pos = 0;
      req.measured_pos = 0;
      req.end_of_period = 0;
      req.wait_periods = 0;
      req.sample_count = 0;
      csr.valid = 1'b0;
      csr.index = REG_GAIN0;
      csr.data = 0;
      reset_mirror();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset all gains are zero
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0), 0));
      directed.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(CMD_NONE, 3, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_item(directed[i]);
      drain();
      directed.delete();

      // extreme gains, short wait
      write_reg(REG_GAIN0, 16'h7fff);
      write_reg(REG_GAIN1, 16'h8000);
      write_reg(REG_GAIN2, 16'h0100);
      write_reg(REG_GAIN3, 16'hff00);
      write_reg(REG_GAIN4, 16'h0001);
      write_reg(REG_GAIN5, 16'hffff);
      write_reg(REG_AXES, 16'd5);
      write_reg(REG_MINWAIT, 16'd0);
      // saturation both ways, rounding of a small positive product, unused axes
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0),
                                  32'h7fffffff));
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 1, 32'h7fffffff, 32'h80000000, 0, 0, 0),
                                  32'h80000000));
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 2, 32'd1234, 32'd34, 0, 0, 0), 32'd1200));
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 4, 32'd1, 32'd0, 0, 0, 0), 32'd0));
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 5, 32'd1, 32'd0, 0, 0, 0), 32'd0));
      directed.push_back(mk_typed(mk(CMD_SAMPLE, 7, 32'd9, 32'd0, 1, 0, 0), 32'd0));
      // start with zero samples, refused second start, a measured period
      directed.push_back(mk(CMD_START, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk(CMD_START, 0, 0, 0, 0, 16'hffff, 16'hffff));
      directed.push_back(mk(CMD_SAMPLE, 0, 32'd500000, 32'd0, 1, 0, 0));
      directed.push_back(mk(CMD_SAMPLE, 1, 32'd0, 32'd800000, 0, 0, 0));
      directed.push_back(mk(CMD_SAMPLE, 3, 32'd70000, 32'd0, 1, 0, 0));
      directed.push_back(mk(CMD_STOP, 0, 0, 0, 1, 0, 0));
      directed.push_back(mk(CMD_SAMPLE, 0, 32'h80000000, 32'h7fffffff, 1, 0, 0));
      directed.push_back(mk(CMD_SAMPLE, 1, 32'd0, 32'd0, 1, 0, 0));
      directed.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // random phases over several settings
      for (int phase = 0; phase < 6; phase++) begin
         for (int g = 0; g < AXIS_COUNT; g++)
            write_reg(reg_type'(g), 16'($urandom));
         write_reg(REG_AXES, (phase == 0) ? 16'd0 : (phase == 1) ? 16'd7
                                                  : 16'($urandom_range(1, 6)));
         write_reg(REG_MINWAIT, (phase == 5) ? 16'hffff : 16'($urandom_range(0, 3)));
         if (phase == 5) calm = 1'b1;
         axes = axes_effective();
         for (int n = 0; n < 2; n++) begin
            if (phase != 5 || n == 0) begin
               ctrl_item_type s;
               s = mk(CMD_START, 0, 0, 0, 0, $urandom_range(0, 3), $urandom_range(0, 4));
               if ($urandom_range(0, 9) == 0)
                  s.sample_count = $urandom_range(0, 1) ? 16'hffff : 16'd0;
               send_item(s);
            end
            periods = $urandom_range(3, 5);
            for (int p = 0; p < periods; p++) begin
               run_period(axes);
               if ($urandom_range(0, 5) == 0) begin
                  ctrl_item_type x;
                  x = random_sample();
                  x.command = cmd_type'($urandom_range(0, 3));
                  x.end_of_period = 1'($urandom_range(0, 1));
                  send_item(x);
               end
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
